[rtl/ipv4bl_pkg.sv]
// Shared types and constants for the IPv4 source blocklist filter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ipv4bl_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;

    // item opcodes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [5:0]  MIN_FRAME_BYTES = 6'd34;
    localparam logic [5:0]  POS_MAX         = 6'd63;
    localparam logic [5:0]  POS_TYPE_HI     = 6'd12;
    localparam logic [5:0]  POS_TYPE_LO     = 6'd13;
    localparam logic [5:0]  POS_SRC_FIRST   = 6'd26;
    localparam logic [5:0]  POS_SRC_LAST    = 6'd29;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] count;
    } t_entry;

    typedef struct packed {
        logic accept;   // take the word on the input channel
        logic clear;    // write an empty entry, advance the sweep address
        logic finish;   // apply the table update and load the result
    } t_dp_cmd;

    typedef struct packed {
        logic item_scan;    // word on the input needs a table scan
        logic item_direct;  // word on the input ends a frame with no lookup
        logic addr_last;    // sweep address is at the last entry
        logic cmp_last;     // last entry is being compared this cycle
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage

[rtl/ipv4bl_ctrl.sv]
// Sequencer of the blocklist filter: clearing pass, item accept, scan, finish.
// Depends on ipv4bl_pkg; drives commands to ipv4bl_dp and reads its status.
`timescale 1ns / 1ps

module ipv4bl_ctrl
    import ipv4bl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.finish = (r_state == S_FINISH) && i_status.out_free;
        o_in_stall   = (r_state != S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.addr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.item_scan) n_state = S_SCAN;
                    else if (i_status.item_direct) n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (i_status.cmp_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_CLEAR)
        else $error("controller did not enter the clearing pass after reset");

    a_scan_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.cmp_last) |=> r_state == S_FINISH)
        else $error("scan end did not lead to finish");

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && i_status.out_free) |=> r_state == S_IDLE)
        else $error("finish with free output did not return to idle");

endmodule

[rtl/ipv4bl_dp.sv]
// Datapath of the blocklist filter: header parser, entry table, scan compare,
// table update and output register. Depends on ipv4bl_pkg.
`timescale 1ns / 1ps

module ipv4bl_dp
    import ipv4bl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_dp_status,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [31:0] i_entry_address,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_verdict,
    output logic [63:0] o_hit_count,
    output logic [1:0]  o_status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    // header parser
    logic [5:0]  r_byte_pos;
    logic        r_eth_ok;
    logic [31:0] r_src;
    logic [5:0]  n_byte_pos;
    logic        n_eth_ok;
    logic [31:0] n_src;
    logic        w_is_byte;
    logic        w_frame_end;
    logic        w_eligible;

    // item and scan
    logic [1:0]    r_op;
    logic [31:0]   r_key;
    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_cmp_v;
    logic [AW-1:0] r_cmp_idx;
    logic          r_found;
    logic [AW-1:0] r_found_idx;
    logic [63:0]   r_found_cnt;
    logic          r_free_hit;
    logic [AW-1:0] r_free_idx;
    logic          w_match;

    // entry table
    t_entry        mem [TABLE_ENTRIES];
    t_entry        r_rd;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    // result
    logic [63:0] w_cnt_inc;
    logic        w_verdict;
    logic [63:0] w_hit_count;
    logic [1:0]  w_status;
    logic        r_out_valid;
    logic        r_verdict;
    logic [63:0] r_hit_count;
    logic [1:0]  r_status;

    always_comb begin
        w_is_byte   = (i_opcode == OP_BYTE);
        w_frame_end = w_is_byte && i_frame_last;
        n_byte_pos  = (r_byte_pos < POS_MAX) ? (r_byte_pos + 6'd1) : POS_MAX;
        n_eth_ok    = r_eth_ok;
        n_src       = r_src;
        if (r_byte_pos == POS_TYPE_HI) begin
            n_eth_ok = (i_frame_byte == ETHERTYPE_IPV4[15:8]);
        end else if (r_byte_pos == POS_TYPE_LO) begin
            n_eth_ok = r_eth_ok && (i_frame_byte == ETHERTYPE_IPV4[7:0]);
        end else if (r_byte_pos inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
            n_src = {r_src[23:0], i_frame_byte};
        end
        w_eligible = (n_byte_pos >= MIN_FRAME_BYTES) && n_eth_ok;

        o_dp_status.item_scan   = (i_opcode == OP_ADD) || (i_opcode == OP_REMOVE)
                                  || (w_frame_end && w_eligible);
        o_dp_status.item_direct = w_frame_end && !w_eligible;
        o_dp_status.addr_last   = (r_addr == LAST_IDX);
        o_dp_status.cmp_last    = r_cmp_v && (r_cmp_idx == LAST_IDX);
        o_dp_status.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_eth_ok   <= 1'b0;
            r_src      <= '0;
        end else if (i_cmd.accept && w_is_byte) begin
            if (i_frame_last) begin
                r_byte_pos <= '0;
                r_eth_ok   <= 1'b0;
                r_src      <= '0;
            end else begin
                r_byte_pos <= n_byte_pos;
                r_eth_ok   <= n_eth_ok;
                r_src      <= n_src;
            end
        end
    end

    assign w_match = r_rd.valid && (r_rd.key == r_key);

    // scan control: one read issued per cycle, compared in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_cmp_v    <= 1'b0;
            r_found    <= 1'b0;
            r_free_hit <= 1'b0;
        end else begin
            r_cmp_v <= r_issue;
            if (i_cmd.accept) begin
                r_addr     <= '0;
                r_issue    <= o_dp_status.item_scan;
                r_found    <= 1'b0;
                r_free_hit <= 1'b0;
            end else begin
                if (r_issue || i_cmd.clear) begin
                    r_addr <= o_dp_status.addr_last ? '0 : (r_addr + 1'b1);
                end
                if (r_issue && o_dp_status.addr_last) r_issue <= 1'b0;
                if (r_cmp_v && w_match) r_found <= 1'b1;
                if (r_cmp_v && !r_rd.valid) r_free_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_key <= w_is_byte ? n_src : i_entry_address;
        end
        // keep the lowest matching and the lowest free index
        if (r_cmp_v && w_match && !r_found) begin
            r_found_idx <= r_cmp_idx;
            r_found_cnt <= r_rd.count;
        end
        if (r_cmp_v && !r_rd.valid && !r_free_hit) r_free_idx <= r_cmp_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        r_rd <= mem[r_addr];
    end

    always_comb begin
        w_cnt_inc   = r_found_cnt + 64'd1;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_data   = '0;
        w_verdict   = 1'b0;
        w_hit_count = '0;
        w_status    = ST_OK;
        if (i_cmd.clear) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.finish) begin
            case (r_op)
                OP_BYTE: begin
                    if (r_found) begin
                        w_wr_en     = 1'b1;
                        w_wr_addr   = r_found_idx;
                        w_wr_data   = '{valid: 1'b1, key: r_key, count: w_cnt_inc};
                        w_verdict   = 1'b1;
                        w_hit_count = w_cnt_inc;
                    end
                end
                OP_ADD: begin
                    if (!r_found) begin
                        if (r_free_hit) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_free_idx;
                            w_wr_data = '{valid: 1'b1, key: r_key, count: 64'd0};
                        end else begin
                            w_status = ST_FULL;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (r_found) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_found_idx;
                        w_wr_data = '{valid: 1'b0, key: r_key, count: r_found_cnt};
                    end else begin
                        w_status = ST_NOT_FOUND;
                    end
                end
                default: w_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_verdict   <= w_verdict;
            r_hit_count <= w_hit_count;
            r_status    <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_hit_count = r_hit_count;
    assign o_status    = r_status;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> !w_wr_en)
        else $error("table write overlaps an active scan");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_status.cmp_last |=> !r_cmp_v)
        else $error("compare continued past the last entry");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item left no result");

endmodule

[rtl/ipv4_source_blocklist_filter.sv]
// Throughput: while idle, non-final frame bytes and unused opcodes are taken one word per
// cycle. A final byte of an IPv4 frame of 34 bytes or more, an add or a remove scans
// the table one entry per cycle through its single read port, with the input stalled
// until the result is loaded. Other frame ends go straight to the finish step.
// Reset: synchronous, active low; a clearing pass then empties the table, with the
// input stalled. Depends on ipv4bl_pkg, ipv4bl_ctrl, ipv4bl_dp.
`timescale 1ns / 1ps

module ipv4_source_blocklist_filter
    import ipv4bl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [31:0] i_entry_address,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_verdict,
    output logic [63:0] o_hit_count,
    output logic [1:0]  o_status
);

    // commands from the sequencer, status back from the datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The sequencer owns the input handshake: it takes a word only when idle,
    // and holds stall through the clearing pass, the scan and the finish step.
    ipv4bl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_stall)
    );

    // The datapath parses the header, scans the table, updates the matched entry
    // or fills a free one, and holds the result in an output register, so the
    // next word can be taken while a result still waits downstream.
    ipv4bl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_dp_status     (w_status),
        .i_opcode        (i_opcode),
        .i_frame_byte    (i_frame_byte),
        .i_frame_last    (i_frame_last),
        .i_entry_address (i_entry_address),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_verdict       (o_verdict),
        .o_hit_count     (o_hit_count),
        .o_status        (o_status)
    );

endmodule

[tb/sv/tb_ipv4_source_blocklist_filter.sv]
`timescale 1ns / 1ps
// Self-checking bench for ipv4_source_blocklist_filter: a frame and table predictor class
// checks every verdict, hit count and status word. Depends on ipv4bl_pkg and the filter RTL.

module tb_ipv4_source_blocklist_filter;
    import ipv4bl_pkg::*;

    localparam int         TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT;
    localparam int         RANDOM_WORDS  = 1570;
    localparam int         POOL_SIZE     = 96;     // larger than the table, so fills overflow
    localparam int         HOLD_START    = 1500;   // receiver cycles before the long hold-off
    localparam int         HOLD_CYCLES   = 600;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         PRINT_LIMIT   = 50;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [7:0] TYPE_HI       = ETHERTYPE_IPV4[15:8];
    localparam logic [7:0] TYPE_LO       = ETHERTYPE_IPV4[7:0];

    // How the ethertype bytes of a generated frame are filled in
    typedef enum int {
        FR_IPV4,    // 0x08 0x00
        FR_BAD_HI,  // first ethertype byte wrong
        FR_BAD_LO,  // 0x08 then a wrong second byte
        FR_NOISE    // both bytes random
    } t_frame_kind;

    typedef struct {
        logic        drop;
        logic [63:0] hits;
        logic [1:0]  status;
    } t_verdict;

    // Tracks frame progress and the blocklist table, and queues the verdict or status
    // word that each accepted frame end, add or remove must produce.
    class verdict_book;
        logic [5:0]  byte_pos;
        logic        type_ok;
        logic [31:0] src_addr;
        logic        live [TABLE_ENTRIES];
        logic [31:0] keys [TABLE_ENTRIES];
        logic [63:0] hits [TABLE_ENTRIES];
        t_verdict    verdicts_due [$];
        int          mismatches;

        function new();
            byte_pos   = '0;
            type_ok    = 1'b0;
            src_addr   = '0;
            mismatches = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                live[i] = 1'b0;
                keys[i] = '0;
                hits[i] = '0;
            end
        endfunction

        function int find_key(logic [31:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (live[i] && keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void take_word(logic [1:0] op, logic [7:0] b, logic last, logic [31:0] addr);
            logic [5:0] seen;
            int         idx;
            t_verdict   v;
            v.drop   = 1'b0;
            v.hits   = '0;
            v.status = ST_OK;
            case (op)
                OP_BYTE: begin
                    if (byte_pos == POS_TYPE_HI)
                        type_ok = (b == TYPE_HI);
                    else if (byte_pos == POS_TYPE_LO)
                        type_ok = type_ok && (b == TYPE_LO);
                    else if (byte_pos >= POS_SRC_FIRST && byte_pos <= POS_SRC_LAST)
                        src_addr = {src_addr[23:0], b};
                    seen = (byte_pos < POS_MAX) ? byte_pos + 6'd1 : POS_MAX;
                    if (!last) begin
                        byte_pos = seen;
                        return;
                    end
                    idx = (seen >= MIN_FRAME_BYTES && type_ok) ? find_key(src_addr) : -1;
                    byte_pos = '0;
                    type_ok  = 1'b0;
                    src_addr = '0;
                    if (idx >= 0) begin
                        hits[idx] = hits[idx] + 64'd1;
                        v.drop    = 1'b1;
                        v.hits    = hits[idx];
                    end
                end
                OP_ADD: begin
                    // present address: leave entry and counter alone
                    if (find_key(addr) < 0) begin
                        idx = -1;
                        for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++)
                            if (!live[i])
                                idx = i;
                        if (idx < 0) begin
                            v.status = ST_FULL;
                        end else begin
                            live[idx] = 1'b1;
                            keys[idx] = addr;
                            hits[idx] = '0;
                        end
                    end
                end
                OP_REMOVE: begin
                    idx = find_key(addr);
                    if (idx < 0)
                        v.status = ST_NOT_FOUND;
                    else
                        live[idx] = 1'b0;
                end
                default: return;
            endcase
            verdicts_due.push_back(v);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_LIMIT)
                $display("%0t ns mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_verdict(logic drop, logic [63:0] hit_count, logic [1:0] status);
            t_verdict v;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word: verdict %0b count %0d status %0d",
                                          drop, hit_count, status));
                return;
            end
            v = verdicts_due.pop_front();
            if (drop !== v.drop)
                report_mismatch($sformatf("verdict %0b, want %0b", drop, v.drop));
            if (hit_count !== v.hits)
                report_mismatch($sformatf("hit count %0d, want %0d", hit_count, v.hits));
            if (status !== v.status)
                report_mismatch($sformatf("status %0d, want %0d", status, v.status));
        endtask
    endclass

    // Every block input starts at a known value
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [1:0]  i_opcode        = OP_BYTE;
    logic [7:0]  i_frame_byte    = '0;
    logic        i_frame_last    = 1'b0;
    logic [31:0] i_entry_address = '0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_verdict;
    logic [63:0] o_hit_count;
    logic [1:0]  o_status;

    verdict_book verdicts = new();
    logic [31:0] pool [POOL_SIZE];   // addresses that both the table ops and frames draw on
    int          burst_left  = 0;
    int          words_sent  = 0;    // accepted words other than unused opcodes
    int          cycle_count = 0;

    ipv4_source_blocklist_filter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_frame_byte   (i_frame_byte),
        .i_frame_last   (i_frame_last),
        .i_entry_address(i_entry_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_verdict      (o_verdict),
        .o_hit_count    (o_hit_count),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Offer one word until o_stall reads low after an edge. The sender works in bursts:
    // when a burst runs out, drop valid for a random gap, then start a new burst. Long
    // bursts give stretches with no idling at all. Called right after a rising edge.
    task automatic push_word(input logic [1:0] op, input logic [7:0] b, input logic last,
                             input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_frame_byte    <= b;
        i_frame_last    <= last;
        i_entry_address <= addr;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    function automatic logic [31:0] pick_source();
        return ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // One random table operation or an ignored word; also slipped into frames.
    task automatic poke_table();
        logic [31:0] a;
        a = pick_source();
        case ($urandom_range(0, 5))
            0, 1, 2: push_word(OP_ADD, 8'($urandom), 1'($urandom), a);
            3, 4:    push_word(OP_REMOVE, 8'($urandom), 1'($urandom), a);
            default: push_word(OP_UNUSED, 8'($urandom), 1'($urandom), $urandom);
        endcase
    endtask

    // Send a frame of len bytes with random content, the ethertype set by kind and
    // the source address placed at its fixed offset. Now and then a table operation
    // or an ignored word goes in before a byte of the frame.
    task automatic send_frame(input int len, input t_frame_kind kind, input logic [31:0] src);
        logic [7:0] b;
        for (int n = 0; n < len; n++) begin
            b = 8'($urandom_range(0, 255));
            if (n == POS_TYPE_HI) begin
                if (kind == FR_BAD_HI)
                    b = (b == TYPE_HI) ? ~b : b;
                else if (kind != FR_NOISE)
                    b = TYPE_HI;
            end else if (n == POS_TYPE_LO) begin
                if (kind == FR_BAD_LO)
                    b = (b == TYPE_LO) ? ~b : b;
                else if (kind != FR_NOISE)
                    b = TYPE_LO;
            end else if (n >= POS_SRC_FIRST && n <= POS_SRC_LAST) begin
                b = src[8 * (POS_SRC_LAST - n) +: 8];
            end
            if ($urandom_range(0, 59) == 0)
                poke_table();
            push_word(OP_BYTE, b, n == len - 1, $urandom);
        end
    endtask

    // Sample both handshakes at the rising edge, before any of this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0)
                verdicts.take_word(i_opcode, i_frame_byte, i_frame_last, i_entry_address);
            if (o_valid === 1'b1 && !i_stall)
                verdicts.check_verdict(o_verdict, o_hit_count, o_status);
        end
    end

    // Watchdog: give up well past the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall on its own pattern of random-length runs at varying rates. Once,
    // hold off for a long stretch so results back up and the block stalls its input.
    initial begin : receiver
        int rate;
        int run;
        int rx_cycles;
        rx_cycles = 0;
        forever begin
            run = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0:       rate = 0;
                1:       rate = 30;
                2:       rate = 60;
                default: rate = 90;
            endcase
            repeat (run) begin
                i_stall <= ($urandom_range(0, 99) < rate);
                @(posedge i_clk);
                rx_cycles++;
                if (rx_cycles == HOLD_START) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int stop_at;
        int round;
        int pick;
        int base;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++)
            pool[k] = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table ops at the address extremes, then the frame corner cases
        push_word(OP_ADD, 8'h00, 1'b0, 32'h0000_0000);      // lowest free entry
        push_word(OP_ADD, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_word(OP_ADD, 8'h00, 1'b0, 32'h0000_0000);      // already present
        push_word(OP_REMOVE, 8'hFF, 1'b1, 32'hA5A5_5A5A);   // absent
        push_word(OP_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);   // ignored by the block
        send_frame(34, FR_IPV4, 32'hFFFF_FFFF);             // shortest frame that is looked up
        send_frame(33, FR_IPV4, 32'hFFFF_FFFF);             // one byte short: pass
        send_frame(1, FR_IPV4, 32'h0000_0000);              // single-byte frame
        send_frame(90, FR_IPV4, 32'h0000_0000);             // byte count saturates
        send_frame(40, FR_BAD_HI, 32'h0000_0000);
        send_frame(40, FR_BAD_LO, 32'hFFFF_FFFF);
        push_word(OP_REMOVE, 8'h00, 1'b0, 32'h0000_0000);
        send_frame(34, FR_IPV4, 32'h0000_0000);             // removed: pass

        // Random: mostly well-formed IPv4 frames against a churning table, with
        // periodic fills past capacity and drains
        stop_at = words_sent + RANDOM_WORDS;
        for (round = 0; words_sent < stop_at; round++) begin
            pick = $urandom_range(0, 99);
            if (round % 20 == 5) begin
                // distinct pool addresses, more than the table holds
                base = $urandom_range(0, POOL_SIZE - 1);
                for (int k = 0; k < TABLE_ENTRIES + 6; k++)
                    push_word(OP_ADD, 8'($urandom), 1'($urandom),
                              pool[(base + k) % POOL_SIZE]);
            end else if (round % 20 == 15) begin
                base = $urandom_range(0, POOL_SIZE - 1);
                for (int k = 0; k < TABLE_ENTRIES - 16; k++)
                    push_word(OP_REMOVE, 8'($urandom), 1'($urandom),
                              pool[(base + k) % POOL_SIZE]);
            end else if (pick < 55) begin
                send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(61, 90)
                                                        : $urandom_range(34, 60),
                           FR_IPV4, pick_source());
            end else if (pick < 65) begin
                if (pick < 60)
                    send_frame($urandom_range(1, 33), FR_IPV4, pick_source());
                else
                    send_frame($urandom_range(34, 60), t_frame_kind'($urandom_range(1, 3)),
                               pick_source());
            end else begin
                poke_table();
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every queued word, then long enough for a stray one to show
        while (verdicts.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (2 * TABLE_ENTRIES + 8) @(posedge i_clk);

        if (verdicts.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
